FILE: design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg - shared types and constants for the ipv4 prefix lease counter
// Address token carried along the seen-address cell row, per-slot status
// and the controller state encoding.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int ADDR_W       = 32;
  localparam int LEN_W        = 6;
  localparam int COUNT_W      = 31;
  localparam int NUM_SLOTS    = 4;
  localparam int CFG_IDX_W    = 4;
  localparam int NUM_CFG_REGS = 8;

  // word travelling down the seen-address cell row
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              dup;
  } seen_tok_t;

  // status of one prefix slot
  typedef struct packed {
    logic match;
    logic over_half;
    logic full;
  } slot_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_DONE
  } plc_state_t;

endpackage

FILE: design/plc_seen_cell.sv
// ----------------------------------------------------------------------------
// plc_seen_cell - one entry of the seen-address row
// Holds one stored address, compares it with the passing word, writes the
// address when this entry is the next free one, and hands the word onward.
// ----------------------------------------------------------------------------
module plc_seen_cell #(
  parameter int CELL_IDX = 0,
  parameter int FILL_W   = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plc_pkg::seen_tok_t    tok_i,
  input  logic [FILL_W-1:0]     fill,
  output plc_pkg::seen_tok_t    tok_o
);
  import plc_pkg::*;

  localparam logic [FILL_W-1:0] IDX_L = FILL_W'(CELL_IDX);

  logic [ADDR_W-1:0] entry_r;
  seen_tok_t         tok_r;
  logic              hit;
  logic              wr_en;

  // entries below the fill count hold real addresses
  assign hit   = tok_i.valid && (fill > IDX_L) && (entry_r == tok_i.addr);
  // all earlier entries are already checked when the word reaches the free one
  assign wr_en = tok_i.valid && !tok_i.dup && (fill == IDX_L);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= tok_i.addr;
    end
  end

  // pass the word to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
    end
    tok_r.addr <= tok_i.addr;
    tok_r.dup  <= tok_i.dup | hit;
  end

  assign tok_o = tok_r;

endmodule

FILE: design/plc_slot.sv
// ----------------------------------------------------------------------------
// plc_slot - one prefix slot
// Holds the network and length registers and the lease count, checks the
// host range of the address and reports over-half and full status.
// ----------------------------------------------------------------------------
module plc_slot #(
  parameter bit ENABLED = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_is_len,
  input  logic [31:0]                   cfg_data,
  input  logic [plc_pkg::ADDR_W-1:0]    addr,
  input  logic                          upd,
  output plc_pkg::slot_stat_t           stat,
  output logic [plc_pkg::COUNT_W-1:0]   count
);
  import plc_pkg::*;

  logic [ADDR_W-1:0]  net_r;
  logic [LEN_W-1:0]   len_r;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               used;
  logic               cap_ok;
  logic [LEN_W-1:0]   shamt;
  logic [ADDR_W-1:0]  net_mask, host, netw, bcast;
  logic [COUNT_W-1:0] cap;

  // prefix decode
  assign used     = ENABLED && (len_r != '0) && (len_r <= LEN_W'(ADDR_W));
  assign cap_ok   = used && (len_r <= LEN_W'(ADDR_W - 2));
  assign shamt    = LEN_W'(ADDR_W) - len_r;
  assign net_mask = used ? ({ADDR_W{1'b1}} << shamt[4:0]) : '0;
  assign host     = ~net_mask;
  assign netw     = net_r & net_mask;
  assign bcast    = netw | host;
  assign cap      = cap_ok ? (host[COUNT_W-1:0] - COUNT_W'(1)) : '0;

  // status
  assign stat.match     = used && ((addr & net_mask) == netw) &&
                          (addr != netw) && (addr != bcast);
  assign stat.over_half = cap_ok && ({count_r, 1'b0} > {1'b0, cap});
  assign stat.full      = cap_ok && (count_r == cap);

  // saturating count
  always_comb begin
    count_nxt = count_r;
    if (upd && stat.match && (count_r < cap)) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_r   <= '0;
      len_r   <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we && !cfg_is_len) begin
        net_r <= cfg_data;
      end
      if (cfg_we && cfg_is_len) begin
        len_r <= cfg_data[LEN_W-1:0];
      end
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

FILE: design/ipv4_prefix_lease_counter.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_lease_counter - per-prefix lease counter with duplicate check
// Flow: an accepted nonzero address walks the SEEN_DEPTH-cell seen-address row,
//   then the controller passes through update and done; a zero address skips
//   the row and goes straight to update. One item at a time.
// Result sits in an output register; the next item is taken once it loads.
// Reset (synchronous, rst_n low): seen store empty, counts and prefix
//   registers zero; stored address entries are not cleared.
// ----------------------------------------------------------------------------
module ipv4_prefix_lease_counter #(
  parameter int SEEN_DEPTH   = 256,
  parameter int PREFIX_SLOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plc_pkg::ADDR_W-1:0]        in_lease_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_ignored,
  output logic                              out_duplicate,
  output logic                              out_store_full,
  output logic [plc_pkg::NUM_SLOTS-1:0]     out_match_mask,
  output logic [plc_pkg::NUM_SLOTS-1:0]     out_over_half_mask,
  output logic [plc_pkg::NUM_SLOTS-1:0]     out_full_mask,
  output logic [plc_pkg::COUNT_W-1:0]       out_count_0,
  output logic [plc_pkg::COUNT_W-1:0]       out_count_1,
  output logic [plc_pkg::COUNT_W-1:0]       out_count_2,
  output logic [plc_pkg::COUNT_W-1:0]       out_count_3,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import plc_pkg::*;

  localparam int FILL_W = $clog2(SEEN_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SEEN_DEPTH);

  plc_state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic                   ign_r, ign_nxt;
  logic                   dup_r, dup_nxt;
  logic                   sfull_r, sfull_nxt;
  logic [NUM_SLOTS-1:0]   match_r, match_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   upd;
  logic                   load;
  logic                   accept;

  logic                   out_valid_r, out_valid_nxt;
  logic                   o_ign_r, o_dup_r, o_sfull_r;
  logic [NUM_SLOTS-1:0]   o_match_r, o_over_r, o_full_r;
  logic [COUNT_W-1:0]     o_count_r [NUM_SLOTS];

  seen_tok_t              chain [SEEN_DEPTH+1];
  slot_stat_t             stat  [NUM_SLOTS];
  logic [COUNT_W-1:0]     count [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   match_vec, over_vec, full_vec;

  assign accept = in_valid && in_ready;

  // word entering the seen-address row
  assign chain[0].valid = accept && (in_lease_addr != '0);
  assign chain[0].addr  = in_lease_addr;
  assign chain[0].dup   = 1'b0;

  // seen-address cell row
  for (genvar g = 0; g < SEEN_DEPTH; g++) begin : g_seen
    plc_seen_cell #(
      .CELL_IDX (g),
      .FILL_W   (FILL_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .fill  (fill_r),
      .tok_o (chain[g+1])
    );
  end

  // prefix slots
  assign cfg_ready = 1'b1;

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    logic we;
    assign we = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS)) &&
                (cfg_index[2:1] == 2'(s));

    plc_slot #(
      .ENABLED (s < PREFIX_SLOTS)
    ) u_slot (
      .clk        (clk),
      .rst_n      (rst_n),
      .cfg_we     (we),
      .cfg_is_len (cfg_index[0]),
      .cfg_data   (cfg_data),
      .addr       (addr_r),
      .upd        (upd),
      .stat       (stat[s]),
      .count      (count[s])
    );

    assign match_vec[s] = stat[s].match;
    assign over_vec[s]  = stat[s].over_half;
    assign full_vec[s]  = stat[s].full;
  end

  // controller next state
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    ign_nxt   = ign_r;
    dup_nxt   = dup_r;
    sfull_nxt = sfull_r;
    match_nxt = match_r;
    fill_nxt  = fill_r;
    in_ready  = 1'b0;
    upd       = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          addr_nxt = in_lease_addr;
          ign_nxt  = (in_lease_addr == '0);
          dup_nxt  = 1'b0;
          state_nxt = (in_lease_addr == '0) ? ST_UPDATE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[SEEN_DEPTH].valid) begin
          dup_nxt   = chain[SEEN_DEPTH].dup;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        upd       = !ign_r && !dup_r;
        match_nxt = upd ? match_vec : '0;
        sfull_nxt = upd && (fill_r == FILL_MAX);
        if (upd && (fill_r != FILL_MAX)) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r  <= addr_nxt;
    ign_r   <= ign_nxt;
    dup_r   <= dup_nxt;
    sfull_r <= sfull_nxt;
    match_r <= match_nxt;
  end

  // output register, counts already hold the update
  always_ff @(posedge clk) begin
    if (load) begin
      o_ign_r   <= ign_r;
      o_dup_r   <= dup_r;
      o_sfull_r <= sfull_r;
      o_match_r <= match_r;
      o_over_r  <= over_vec;
      o_full_r  <= full_vec;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        o_count_r[i] <= count[i];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ignored        = o_ign_r;
  assign out_duplicate      = o_dup_r;
  assign out_store_full     = o_sfull_r;
  assign out_match_mask     = o_match_r;
  assign out_over_half_mask = o_over_r;
  assign out_full_mask      = o_full_r;
  assign out_count_0        = o_count_r[0];
  assign out_count_1        = o_count_r[1];
  assign out_count_2        = o_count_r[2];
  assign out_count_3        = o_count_r[3];

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("seen fill count beyond store depth");

  a_word_exit: assert property (@(posedge clk) disable iff (!rst_n)
    chain[SEEN_DEPTH].valid |-> state_r == ST_SEARCH)
    else $error("search word left the cell row outside a search");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (o_ign_r || o_dup_r)) |-> (o_match_r == '0))
    else $error("match reported for an ignored or duplicate address");

endmodule

FILE: verif/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker - scoreboard for the ipv4 prefix lease counter
// Watches the config, lease and result channels. Keeps its own copy of the
// prefix registers, the seen-address list and the per-slot counts, works out
// the result word for every accepted lease and compares each result word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module plc_checker #(
  parameter int SEEN_DEPTH   = 256,
  parameter int PREFIX_SLOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [plc_pkg::ADDR_W-1:0]        in_lease_addr,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_ignored,
  input  logic                              out_duplicate,
  input  logic                              out_store_full,
  input  logic [plc_pkg::NUM_SLOTS-1:0]     out_match_mask,
  input  logic [plc_pkg::NUM_SLOTS-1:0]     out_over_half_mask,
  input  logic [plc_pkg::NUM_SLOTS-1:0]     out_full_mask,
  input  logic [plc_pkg::COUNT_W-1:0]       out_count_0,
  input  logic [plc_pkg::COUNT_W-1:0]       out_count_1,
  input  logic [plc_pkg::COUNT_W-1:0]       out_count_2,
  input  logic [plc_pkg::COUNT_W-1:0]       out_count_3,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  output int                                errors,
  output int                                pending,
  output int                                dup_seen,
  output int                                overflow_seen,
  output int                                capped_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import plc_pkg::*;

  // one result word as the block reports it
  typedef struct packed {
    logic                              ignored;
    logic                              duplicate;
    logic                              store_full;
    logic [NUM_SLOTS-1:0]              match_mask;
    logic [NUM_SLOTS-1:0]              over_half_mask;
    logic [NUM_SLOTS-1:0]              full_mask;
    logic [NUM_SLOTS-1:0][COUNT_W-1:0] count;
  } lease_tally_t;

  // shadow of the block state
  logic [ADDR_W-1:0]  prefix_base [NUM_SLOTS];
  logic [LEN_W-1:0]   prefix_len  [NUM_SLOTS];
  logic [COUNT_W-1:0] lease_count [NUM_SLOTS];
  logic [ADDR_W-1:0]  seen_list [$];
  lease_tally_t       tally_q [$];

  // slot takes part only with a length of 1 to 32
  function automatic bit slot_live(int s);
    return s < PREFIX_SLOTS && prefix_len[s] >= 1 && prefix_len[s] <= 32;
  endfunction

  function automatic logic [31:0] slot_netmask(int s);
    return 32'hFFFF_FFFF << (32 - int'(prefix_len[s]));
  endfunction

  // usable hosts, zero for /31 and /32
  function automatic logic [31:0] host_cap(int s);
    if (!slot_live(s) || prefix_len[s] >= 31) return 32'd0;
    return (32'd1 << (32 - int'(prefix_len[s]))) - 32'd2;
  endfunction

  // inside the network, not the network or broadcast address
  function automatic bit slot_holds(int s, logic [31:0] a);
    logic [31:0] m;
    logic [31:0] base;
    if (!slot_live(s)) return 1'b0;
    m = slot_netmask(s);
    base = prefix_base[s] & m;
    return (a & m) == base && a != base && a != (base | ~m);
  endfunction

  // advance the shadow state by one lease and build its result word
  function automatic lease_tally_t tally_lease(logic [31:0] a);
    lease_tally_t t;
    logic [31:0] cap;
    t = '0;
    if (a == '0) begin
      t.ignored = 1'b1;
    end else begin
      foreach (seen_list[i])
        if (seen_list[i] == a) t.duplicate = 1'b1;
      if (!t.duplicate) begin
        if (seen_list.size() < SEEN_DEPTH) seen_list.push_back(a);
        else t.store_full = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_holds(s, a)) begin
            t.match_mask[s] = 1'b1;
            if (lease_count[s] < host_cap(s)) lease_count[s] = lease_count[s] + 1'b1;
            else capped_hits++;
          end
        end
      end
    end
    // status masks reflect the counts after the update
    for (int s = 0; s < NUM_SLOTS; s++) begin
      cap = host_cap(s);
      if (cap != '0) begin
        t.over_half_mask[s] = {lease_count[s], 1'b0} > cap;
        t.full_mask[s] = lease_count[s] == cap;
      end
      t.count[s] = lease_count[s];
    end
    return t;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // channel monitor
  always @(posedge clk) begin : watch
    lease_tally_t want;
    lease_tally_t got;
    if (!rst_n) begin
      foreach (prefix_base[s]) begin
        prefix_base[s] = '0;
        prefix_len[s]  = '0;
        lease_count[s] = '0;
      end
      seen_list.delete();
      tally_q.delete();
      errors = 0;
      pending = 0;
      dup_seen = 0;
      overflow_seen = 0;
      capped_hits = 0;
    end else begin
      // register write: even index is a network, odd index a length
      if (cfg_valid && cfg_ready && cfg_index < NUM_CFG_REGS) begin
        if (cfg_index[0]) prefix_len[cfg_index >> 1] = cfg_data[LEN_W-1:0];
        else prefix_base[cfg_index >> 1] = cfg_data;
      end

      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        got.ignored        = out_ignored;
        got.duplicate      = out_duplicate;
        got.store_full     = out_store_full;
        got.match_mask     = out_match_mask;
        got.over_half_mask = out_over_half_mask;
        got.full_mask      = out_full_mask;
        got.count[0]       = out_count_0;
        got.count[1]       = out_count_1;
        got.count[2]       = out_count_2;
        got.count[3]       = out_count_3;
        if (tally_q.size() == 0) begin
          $error("result word with no lease outstanding");
          errors++;
        end else begin
          want = tally_q.pop_front();
          if (want.duplicate) dup_seen++;
          if (want.store_full) overflow_seen++;
          check_field("ignored", want.ignored, got.ignored);
          check_field("duplicate", want.duplicate, got.duplicate);
          check_field("store_full", want.store_full, got.store_full);
          check_field("match_mask", want.match_mask, got.match_mask);
          check_field("over_half_mask", want.over_half_mask, got.over_half_mask);
          check_field("full_mask", want.full_mask, got.full_mask);
          for (int s = 0; s < NUM_SLOTS; s++)
            check_field($sformatf("count_%0d", s), want.count[s], got.count[s]);
        end
      end

      // accepted lease
      if (in_valid && in_ready) tally_q.push_back(tally_lease(in_lease_addr));
      pending = tally_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - regression bench for the ipv4 prefix lease counter
// Directed leases around network, broadcast, duplicate and saturation corners,
// then random phases under fresh prefix settings with random idling on both
// channels, a long result back-pressure stretch and a mid-phase drain. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import plc_pkg::*;

  localparam int SEEN_DEPTH       = 256;
  localparam int PREFIX_SLOTS     = 4;
  localparam int IDLE_PCT         = 23;
  localparam int PHASES           = 6;
  localparam int LEASES_PER_PHASE = 255;
  localparam int HOLD_CYCLES      = 4 * (SEEN_DEPTH + 4);
  localparam int DRAIN_CYCLES     = SEEN_DEPTH + 8;
  localparam logic [CFG_IDX_W-1:0] REG_NET_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_0 = 4'd1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [ADDR_W-1:0]      in_lease_addr;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_ignored;
  logic                   out_duplicate;
  logic                   out_store_full;
  logic [NUM_SLOTS-1:0]   out_match_mask;
  logic [NUM_SLOTS-1:0]   out_over_half_mask;
  logic [NUM_SLOTS-1:0]   out_full_mask;
  logic [COUNT_W-1:0]     out_count_0;
  logic [COUNT_W-1:0]     out_count_1;
  logic [COUNT_W-1:0]     out_count_2;
  logic [COUNT_W-1:0]     out_count_3;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [31:0]            cfg_data;

  int errors;
  int pending;
  int dup_seen;
  int overflow_seen;
  int capped_hits;

  // stimulus bookkeeping
  bit                calm;
  int                hold_requests;
  int                leases_sent;
  int                zeros_sent;
  int                cfg_writes;
  int                stray_writes;
  int                settings;
  logic [ADDR_W-1:0] cur_base [NUM_SLOTS];
  logic [LEN_W-1:0]  cur_len  [NUM_SLOTS];
  logic [ADDR_W-1:0] lease_history [$];

  ipv4_prefix_lease_counter #(
    .SEEN_DEPTH   (SEEN_DEPTH),
    .PREFIX_SLOTS (PREFIX_SLOTS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_lease_addr      (in_lease_addr),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ignored        (out_ignored),
    .out_duplicate      (out_duplicate),
    .out_store_full     (out_store_full),
    .out_match_mask     (out_match_mask),
    .out_over_half_mask (out_over_half_mask),
    .out_full_mask      (out_full_mask),
    .out_count_0        (out_count_0),
    .out_count_1        (out_count_1),
    .out_count_2        (out_count_2),
    .out_count_3        (out_count_3),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  plc_checker #(
    .SEEN_DEPTH   (SEEN_DEPTH),
    .PREFIX_SLOTS (PREFIX_SLOTS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_lease_addr      (in_lease_addr),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ignored        (out_ignored),
    .out_duplicate      (out_duplicate),
    .out_store_full     (out_store_full),
    .out_match_mask     (out_match_mask),
    .out_over_half_mask (out_over_half_mask),
    .out_full_mask      (out_full_mask),
    .out_count_0        (out_count_0),
    .out_count_1        (out_count_1),
    .out_count_2        (out_count_2),
    .out_count_3        (out_count_3),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .errors             (errors),
    .pending            (pending),
    .dup_seen           (dup_seen),
    .overflow_seen      (overflow_seen),
    .capped_hits        (capped_hits)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #40_000_000;
    $display("ipv4_prefix_lease_counter regression: fail");
    $finish;
  end

  // result sink: random stalls, calm stretch, and a long hold on request
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // one register word, held until taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx >= NUM_CFG_REGS) stray_writes++;
    @(posedge clk);
  endtask

  // network and length of one slot, in either order
  task automatic load_slot(input int s, input logic [31:0] base, input logic [31:0] len_word);
    logic [CFG_IDX_W-1:0] net_idx;
    logic [CFG_IDX_W-1:0] len_idx;
    net_idx = REG_NET_0 + CFG_IDX_W'(2 * s);
    len_idx = REG_LEN_0 + CFG_IDX_W'(2 * s);
    if ($urandom_range(1)) begin
      write_reg(net_idx, base);
      write_reg(len_idx, len_word);
    end else begin
      write_reg(len_idx, len_word);
      write_reg(net_idx, base);
    end
    cur_base[s] = base;
    cur_len[s]  = len_word[LEN_W-1:0];
  endtask

  // one lease word, with random idle cycles ahead of it
  task automatic push_lease(input logic [31:0] a);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_lease_addr <= a;
    do @(posedge clk); while (!in_ready);
    leases_sent++;
    if (a == '0) zeros_sent++;
    else lease_history.push_back(a);
  endtask

  // stop sending and wait for every result word, plus a latency margin
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // prefix lengths weighted toward small networks so counts saturate
  function automatic logic [LEN_W-1:0] random_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return LEN_W'($urandom_range(30, 26));
    if (r < 65) return LEN_W'($urandom_range(25, 16));
    if (r < 75) return LEN_W'($urandom_range(15, 1));
    if (r < 85) return LEN_W'($urandom_range(32, 31));
    if (r < 92) return '0;
    return LEN_W'($urandom_range(63, 33));
  endfunction

  // new prefix setting; phase 1 holds the extremes
  task automatic program_slots(input int p);
    logic [31:0] base;
    logic [31:0] len_word;
    int first;
    int s;
    first = $urandom_range(NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = (first + k) % NUM_SLOTS;
      if (p == 1) begin
        case (s)
          0:       begin base = 32'h0000_0000; len_word = 32'd1;         end
          1:       begin base = 32'hFFFF_FFFF; len_word = 32'd1;         end
          2:       begin base = 32'hFFFF_FFFF; len_word = 32'd32;        end
          default: begin base = 32'h0000_0000; len_word = 32'hFFFF_FFFF; end
        endcase
      end else begin
        // sometimes overlap the slot written just before
        if (k > 0 && $urandom_range(2) == 0)
          base = cur_base[(s + NUM_SLOTS - 1) % NUM_SLOTS] ^ 32'($urandom_range(255));
        else
          base = $urandom;
        len_word = $urandom;
        len_word[LEN_W-1:0] = random_len();
        if ($urandom_range(1)) len_word[31:LEN_W] = '0;
      end
      load_slot(s, base, len_word);
    end
    repeat ($urandom_range(2))
      write_reg(CFG_IDX_W'($urandom_range(15, NUM_CFG_REGS)), $urandom);
  endtask

  // mostly hosts of configured slots, some repeats, zeros and raw words
  function automatic logic [31:0] pick_lease();
    int roll;
    int s;
    int r;
    logic [31:0] m;
    logic [31:0] base;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 19 && lease_history.size() > 0)
      return lease_history[$urandom_range(lease_history.size() - 1)];
    if (roll < 79) begin
      s = $urandom_range(NUM_SLOTS - 1);
      if (cur_len[s] >= 1 && cur_len[s] <= 32) begin
        m = 32'hFFFF_FFFF << (32 - int'(cur_len[s]));
        base = cur_base[s] & m;
        r = $urandom_range(9);
        if (r == 0) return base;
        if (r == 1) return base | ~m;
        return base | ($urandom & ~m);
      end
    end
    return $urandom;
  endfunction

  // main stimulus and verdict
  initial begin : stimulus
    logic [31:0] a;
    in_valid      <= 1'b0;
    in_lease_addr <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    calm = 1'b0;
    hold_requests = 0;
    leases_sent = 0;
    zeros_sent = 0;
    cfg_writes = 0;
    stray_writes = 0;
    settings = 0;
    foreach (cur_base[s]) begin
      cur_base[s] = '0;
      cur_len[s]  = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // overlapping /30 and /24, a /31, a length above 32, unmapped indexes
    load_slot(0, 32'hC0A8_0107, 32'd30);
    load_slot(1, 32'hC0A8_0100, 32'd24);
    load_slot(2, 32'hC0A8_0100, 32'd31);
    load_slot(3, 32'h0000_0000, 32'hFFFF_FFE8);
    write_reg(4'd15, 32'hFFFF_FFFF);
    write_reg(NUM_CFG_REGS, 32'h0000_0000);
    settings++;
    push_lease(32'h0000_0000);   // zero address
    push_lease(32'hFFFF_FFFF);
    push_lease(32'hC0A8_0100);   // network address of the /24
    push_lease(32'hC0A8_01FF);   // broadcast of the /24
    push_lease(32'hC0A8_0104);   // network of the /30, host of the /24
    push_lease(32'hC0A8_0105);
    push_lease(32'hC0A8_0105);   // duplicate
    push_lease(32'hC0A8_0106);   // fills the /30
    push_lease(32'hC0A8_0107);   // broadcast of the /30
    push_lease(32'h0000_0000);
    push_lease(32'h0000_0001);
    push_lease(32'h8000_0000);
    settle();

    // full /30 moved elsewhere, /29 nearly full, /1, /32
    load_slot(0, 32'h0B00_0000, 32'd30);
    load_slot(1, 32'h0A00_0000, 32'd29);
    load_slot(2, 32'h8000_0000, 32'd1);
    load_slot(3, 32'hC0A8_0105, 32'd32);
    settings++;
    push_lease(32'h0B00_0001);   // saturated slot still matches
    push_lease(32'h0B00_0002);
    push_lease(32'h0B00_0003);
    push_lease(32'h0A00_0001);
    push_lease(32'h0A00_0002);   // reaches capacity
    push_lease(32'h0A00_0003);   // held at capacity
    push_lease(32'hFFFF_FFFE);
    push_lease(32'hC0A8_0105);

    // random phases, store fills part way through
    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_slots(p);
      settings++;
      calm = (p == 4);
      for (int n = 0; n < LEASES_PER_PHASE; ) begin
        a = pick_lease();
        push_lease(a);
        if (a != '0) begin
          n++;
          if (p == 2 && n == 60) hold_requests++;
          if (p == 3 && n == 100) settle();
          if (p == 4 && n == 120) calm = 1'b0;
        end
      end
    end
    settle();

    $display("covered %0d leases (%0d zero, %0d duplicate, %0d past a full store) over %0d settings",
             leases_sent, zeros_sent, dup_seen, overflow_seen, settings);
    $display("covered %0d hits on capped slots, %0d register writes (%0d unmapped)",
             capped_hits, cfg_writes, stray_writes);
    if (errors == 0 && pending == 0) begin
      $display("ipv4_prefix_lease_counter regression: pass");
    end else begin
      $display("ipv4_prefix_lease_counter regression: fail");
    end
    $finish;
  end

endmodule
